FILE: sv/chxy_pkg.sv
// Shared types and constants for the compass heading block.
// Holds the CORDIC arctangent table, datapath widths, register indexes and octant codes.
// No dependencies.
package chxy_pkg;

    // Arctangent accumulator: units of 2^-24 degree
    localparam int ACC_FRAC  = 24;
    localparam int PRESCALE  = 20;
    localparam int TABLE_LEN = 24;

    // CORDIC x/y width: 17-bit magnitude, 20-bit prescale, gain and sign headroom
    localparam int CORDIC_W  = 41;
    // Angle accumulator width: the sum of the whole table stays below 2^31
    localparam int ZACC_W    = 32;
    // Magnitude width of a corrected axis
    localparam int MAG_W     = 17;

    // Configuration register indexes
    localparam logic [1:0] REG_OFFSET_X    = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y    = 2'd1;
    localparam logic [1:0] REG_DECLINATION = 2'd2;

    // Compass octants
    typedef enum logic [2:0] {
        OCT_N  = 3'd0,
        OCT_NE = 3'd1,
        OCT_E  = 3'd2,
        OCT_SE = 3'd3,
        OCT_S  = 3'd4,
        OCT_SW = 3'd5,
        OCT_W  = 3'd6,
        OCT_NW = 3'd7
    } octant_t;

    // Quadrant and special-case flags that travel beside the CORDIC data
    typedef struct packed {
        logic base90;   // dx negative: heading is 90 +/- phi, else 270 +/- phi
        logic minus;    // subtract phi from the base
        logic a_zero;   // numerator zero: phi is 0
        logic b_zero;   // denominator zero: phi is 90 degrees
    } side_t;

    // atan(2^-i) in units of 2^-24 degree, rounded to nearest
    function automatic logic [30:0] atan_q24(input int i);
        logic [30:0] r;
        case (i)
            0:       r = 31'd754974720;
            1:       r = 31'd445687602;
            2:       r = 31'd235489088;
            3:       r = 31'd119537938;
            4:       r = 31'd60000934;
            5:       r = 31'd30029717;
            6:       r = 31'd15018523;
            7:       r = 31'd7509720;
            8:       r = 31'd3754917;
            9:       r = 31'd1877466;
            10:      r = 31'd938734;
            11:      r = 31'd469367;
            12:      r = 31'd234684;
            13:      r = 31'd117342;
            14:      r = 31'd58671;
            15:      r = 31'd29335;
            16:      r = 31'd14668;
            17:      r = 31'd7334;
            18:      r = 31'd3667;
            19:      r = 31'd1833;
            20:      r = 31'd917;
            21:      r = 31'd458;
            22:      r = 31'd229;
            23:      r = 31'd115;
            default: r = 31'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/chxy_cordic_cell.sv
// One vectoring CORDIC cell: a fixed shift, a table angle and a pipeline register.
// Depends on chxy_pkg for widths, the arctangent table and the side flags.
module chxy_cordic_cell
    import chxy_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [CORDIC_W-1:0] in_x,
    input  logic signed [CORDIC_W-1:0] in_y,
    input  logic signed [ZACC_W-1:0]   in_z,
    input  side_t                      in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [CORDIC_W-1:0] out_x,
    output logic signed [CORDIC_W-1:0] out_y,
    output logic signed [ZACC_W-1:0]   out_z,
    output side_t                      out_side
);

    localparam logic signed [ZACC_W-1:0] ANGLE = ZACC_W'(atan_q24(STAGE));

    logic                       valid_reg;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [ZACC_W-1:0]   z_reg, z_next;
    side_t                      side_reg;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;

    // Take a new item when empty or when the neighbour takes ours
    assign in_ready = !valid_reg || out_ready;

    // Rotate toward the x axis; arithmetic shift rounds toward minus infinity
    always_comb
    begin
        xs = in_x >>> STAGE;
        ys = in_y >>> STAGE;
        if (!in_y[CORDIC_W-1])
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ANGLE;
        end
        else
        begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ANGLE;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

FILE: sv/chxy_finish.sv
// Heading finish: rounds the CORDIC angle, applies the quadrant formula, adds the
// declination, wraps by 360 degrees and classifies the octant. Depends on chxy_pkg.
module chxy_finish
    import chxy_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ZACC_W-1:0] in_z,
    input  side_t                    in_side,
    input  logic signed [14:0]       declination,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [14:0]              heading,
    output logic [2:0]               octant
);

    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int PW = ANGLE_FRAC_BITS + 7;
    localparam int HW = ((ANGLE_FRAC_BITS + 9 > 15) ? ANGLE_FRAC_BITS + 9 : 15) + 2;

    localparam logic signed [ZACC_W-1:0] ROUND   = ZACC_W'(1) <<< (SH - 1);
    localparam logic signed [ZACC_W-1:0] Z_FULL  = ZACC_W'(90) <<< ANGLE_FRAC_BITS;
    localparam logic [PW-1:0]            PHI_90  = PW'(90) << ANGLE_FRAC_BITS;
    localparam logic signed [HW-1:0]     BASE_90  = HW'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [HW-1:0]     BASE_270 = HW'(270) <<< ANGLE_FRAC_BITS;
    localparam logic signed [HW-1:0]     FULL_360 = HW'(360) <<< ANGLE_FRAC_BITS;
    localparam logic signed [HW-1:0]     U        = HW'(45) <<< (ANGLE_FRAC_BITS - 1);

    logic                    a_valid_reg, b_valid_reg, c_valid_reg;
    logic                    a_ready, b_ready, c_ready;

    logic [PW-1:0]           phi_reg, phi_next;
    logic                    base90_reg;
    logic                    minus_reg;
    logic signed [ZACC_W-1:0] z_round;

    logic signed [HW-1:0]    h_reg, h_next;
    logic signed [HW-1:0]    h_base;
    logic signed [HW-1:0]    h_wrap;
    logic                    decl_pos;

    logic [14:0]             heading_reg;
    octant_t                 octant_reg, octant_next;

    // Ready ripples back through the three finish registers
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Round to the angle unit, ties up, clamp to 0..90 degrees, apply special cases
    always_comb
    begin
        z_round = (in_z + ROUND) >>> SH;
        if (in_side.a_zero)
        begin
            phi_next = '0;
        end
        else if (in_side.b_zero)
        begin
            phi_next = PHI_90;
        end
        else if (z_round[ZACC_W-1])
        begin
            phi_next = '0;
        end
        else if (z_round > Z_FULL)
        begin
            phi_next = PHI_90;
        end
        else
        begin
            phi_next = z_round[PW-1:0];
        end
    end

    // Quadrant formula plus declination
    always_comb
    begin
        h_base = base90_reg ? BASE_90 : BASE_270;
        if (minus_reg)
        begin
            h_next = h_base - HW'(phi_reg) + HW'(declination);
        end
        else
        begin
            h_next = h_base + HW'(phi_reg) + HW'(declination);
        end
    end

    // Wrap once in the direction of the declination sign, then classify
    always_comb
    begin
        decl_pos = !declination[14] && (declination != '0);
        h_wrap   = h_reg;
        if (decl_pos && (h_reg > FULL_360))
        begin
            h_wrap = h_reg - FULL_360;
        end
        else if (!decl_pos && h_reg[HW-1])
        begin
            h_wrap = h_reg + FULL_360;
        end

        if ((h_wrap > 15 * U) || (h_wrap < U))
        begin
            octant_next = OCT_N;
        end
        else if (h_wrap > 13 * U)
        begin
            octant_next = OCT_NW;
        end
        else if (h_wrap > 11 * U)
        begin
            octant_next = OCT_W;
        end
        else if (h_wrap > 9 * U)
        begin
            octant_next = OCT_SW;
        end
        else if (h_wrap > 7 * U)
        begin
            octant_next = OCT_S;
        end
        else if (h_wrap > 5 * U)
        begin
            octant_next = OCT_SE;
        end
        else if (h_wrap > 3 * U)
        begin
            octant_next = OCT_E;
        end
        else
        begin
            octant_next = OCT_NE;
        end
    end

    // Hold the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Advance the payload registers
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            phi_reg    <= phi_next;
            base90_reg <= in_side.base90;
            minus_reg  <= in_side.minus;
        end
        if (b_ready)
        begin
            h_reg <= h_next;
        end
        if (c_ready)
        begin
            heading_reg <= h_wrap[14:0];
            octant_reg  <= octant_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign heading   = heading_reg;
    assign octant    = octant_reg;

endmodule

FILE: sv/compass_heading_from_xy.sv
// Compass heading from raw X/Y magnetometer samples: top level.
// Depends on chxy_pkg, chxy_cordic_cell and chxy_finish.
//
// Usage:
//   s_tdata carries one item: x_raw in bits 15:0, y_raw in bits 31:16. Each
//   accepted item yields exactly one result on m_tdata: heading (units of
//   2^-ANGLE_FRAC_BITS degree, 0..360 inclusive) in bits 14:0, octant in 17:15.
//   Items are taken one per clock while s_tready is high. The path holds
//   one input register, one register per CORDIC cell and three finish
//   registers; the default is 16 cells.
//   Throughput is set by the pipelined cell chain: one item per cycle when no stage stalls.
//   The cfg port writes offset_x_twice (index 0), offset_y_twice (1) and
//   declination (2) in the cycle cfg_wen is high; unknown indexes are ignored.
//   Write configuration only while no item is in flight.
//   Reset empties the pipeline and loads offsets 65536 and declination 218.
//   When m_tready is low, the result is held; each register stage keeps taking
//   items until it is full, so s_tready falls only once every stage holds one.
module compass_heading_from_xy
    import chxy_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int CORDIC_STAGES   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_raw [15:0], y_raw [31:16]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // heading [14:0], octant [17:15], zero [23:18]
);

    logic [16:0]        off_x_reg;
    logic [16:0]        off_y_reg;
    logic signed [14:0] decl_reg;

    logic [15:0]        x_raw;
    logic [15:0]        y_raw;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [MAG_W-1:0]   mag_a;
    logic [MAG_W-1:0]   mag_b;
    side_t              side_next;

    logic                       pre_valid_reg;
    logic                       pre_ready;
    logic signed [CORDIC_W-1:0] pre_x_reg, pre_x_next;
    logic signed [CORDIC_W-1:0] pre_y_reg, pre_y_next;
    side_t                      pre_side_reg;

    logic                       link_valid [0:CORDIC_STAGES];
    logic                       link_ready [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] link_x     [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] link_y     [0:CORDIC_STAGES];
    logic signed [ZACC_W-1:0]   link_z     [0:CORDIC_STAGES];
    side_t                      link_side  [0:CORDIC_STAGES];

    logic [14:0]        heading;
    logic [2:0]         octant;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg <= 17'd65536;
            off_y_reg <= 17'd65536;
            decl_reg  <= 15'sd218;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_OFFSET_X:    off_x_reg <= cfg_data;
                REG_OFFSET_Y:    off_y_reg <= cfg_data;
                REG_DECLINATION: decl_reg  <= cfg_data[14:0];
                default:         ;
            endcase
        end
    end

    // Remove offsets, pick the quadrant, form the CORDIC start vector
    always_comb
    begin
        x_raw = s_tdata[15:0];
        y_raw = s_tdata[31:16];
        dx    = $signed({1'b0, x_raw, 1'b0}) - $signed({1'b0, off_x_reg});
        dy    = $signed({1'b0, y_raw, 1'b0}) - $signed({1'b0, off_y_reg});
        mag_a = dy[17] ? MAG_W'(-dy) : dy[MAG_W-1:0];
        mag_b = dx[17] ? MAG_W'(-dx) : dx[MAG_W-1:0];
        side_next.base90 = dx[17];
        side_next.minus  = dx[17] ? (!dy[17] && (dy != '0)) : dy[17];
        side_next.a_zero = (dy == '0);
        side_next.b_zero = (dx == '0);
        pre_x_next = $signed({{(CORDIC_W - MAG_W - PRESCALE){1'b0}}, mag_b,
                              {PRESCALE{1'b0}}});
        pre_y_next = $signed({{(CORDIC_W - MAG_W - PRESCALE){1'b0}}, mag_a,
                              {PRESCALE{1'b0}}});
    end

    assign pre_ready = !pre_valid_reg || link_ready[0];
    assign s_tready  = pre_ready;

    // Hold the input register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (pre_ready)
        begin
            pre_valid_reg <= s_tvalid;
        end
    end

    // Advance the input register payload
    always_ff @(posedge clk)
    begin
        if (pre_ready)
        begin
            pre_x_reg    <= pre_x_next;
            pre_y_reg    <= pre_y_next;
            pre_side_reg <= side_next;
        end
    end

    assign link_valid[0] = pre_valid_reg;
    assign link_x[0]     = pre_x_reg;
    assign link_y[0]     = pre_y_reg;
    assign link_z[0]     = '0;
    assign link_side[0]  = pre_side_reg;

    // Row of CORDIC cells, one shift each
    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_cell
            chxy_cordic_cell #(
                .STAGE (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (link_valid[i]),
                .in_ready  (link_ready[i]),
                .in_x      (link_x[i]),
                .in_y      (link_y[i]),
                .in_z      (link_z[i]),
                .in_side   (link_side[i]),
                .out_valid (link_valid[i+1]),
                .out_ready (link_ready[i+1]),
                .out_x     (link_x[i+1]),
                .out_y     (link_y[i+1]),
                .out_z     (link_z[i+1]),
                .out_side  (link_side[i+1])
            );
        end
    endgenerate

    // Round, apply quadrant and declination, classify
    chxy_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (link_valid[CORDIC_STAGES]),
        .in_ready    (link_ready[CORDIC_STAGES]),
        .in_z        (link_z[CORDIC_STAGES]),
        .in_side     (link_side[CORDIC_STAGES]),
        .declination (decl_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .heading     (heading),
        .octant      (octant)
    );

    assign m_tdata = {6'd0, octant, heading};

endmodule

FILE: tb/tb_compass_heading_from_xy.sv
// Self-checking testbench for compass_heading_from_xy: directed table, then random items
// under three idle patterns and changing offsets and declination, checked against a predictor.
// Depends on chxy_pkg and compass_heading_from_xy.
`timescale 1ns / 100ps

module tb_compass_heading_from_xy;
    import chxy_pkg::*;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STAGES   = 16;
    localparam int ACC_FRAC_BITS   = 24;
    localparam int PRESCALE_BITS   = 20;
    localparam longint RIGHT_ANGLE = longint'(90) << ANGLE_FRAC_BITS;
    localparam longint FULL_TURN   = longint'(360) << ANGLE_FRAC_BITS;
    // Unused register index: writes there must change nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES  = CORDIC_STAGES + 14;
    localparam int LONG_HOLD     = 300;
    localparam int CHUNK_ITEMS   = 67;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [14:0] heading;
        octant_t     octant;
    } heading_item_t;

    typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [1:0]    reg_idx;
        logic [16:0]   wdata;
        logic [15:0]   x;
        logic [15:0]   y;
        logic          typed;
        heading_item_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [16:0] cfg_data = 17'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Predictor copy of the registers
    logic [16:0]        off_x_q = 17'd65536;
    logic [16:0]        off_y_q = 17'd65536;
    logic signed [14:0] decl_q  = 15'sd218;

    // atan(2^-i) in units of 2^-24 degree
    longint atan_tab [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    heading_item_t pending_headings [$];
    stim_row_t     directed_rows [$];
    int            mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int            tx_idle_pct = 13;
    int            rx_idle_pct = 54;
    logic          long_hold_req = 1'b0;
    logic          hold_taken;
    int            hold_left;

    compass_heading_from_xy #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // x_raw [15:0], y_raw [31:16]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // heading [14:0], octant [17:15], zero [23:18]
    );

    always #1 clk = ~clk;

    function automatic octant_t octant_of_heading(input longint h);
        longint u;
        u = longint'(45) << (ANGLE_FRAC_BITS - 1);
        if (h > 15 * u || h < u) return OCT_N;
        if (h > 13 * u) return OCT_NW;
        if (h > 11 * u) return OCT_W;
        if (h > 9 * u) return OCT_SW;
        if (h > 7 * u) return OCT_S;
        if (h > 5 * u) return OCT_SE;
        if (h > 3 * u) return OCT_E;
        return OCT_NE;
    endfunction

    // Heading and octant for one sample under the current registers
    function automatic heading_item_t predict_heading(input logic [15:0] x, input logic [15:0] y);
        longint dx, dy, a, b, base, phi, h, cx, cy, cz, xs, ys;
        logic minus;
        heading_item_t r;
        dx = 2 * longint'(x) - longint'(off_x_q);
        dy = 2 * longint'(y) - longint'(off_y_q);
        // Quadrant from the signs of the corrected axes
        if (dx < 0)
        begin
            b = -dx;
            base = RIGHT_ANGLE;
            minus = (dy > 0);
            a = (dy > 0) ? dy : -dy;
        end
        else
        begin
            b = dx;
            base = 3 * RIGHT_ANGLE;
            minus = (dy < 0);
            a = (dy < 0) ? -dy : dy;
        end
        if (a == 0)
            phi = 0;
        else if (b == 0)
            phi = RIGHT_ANGLE;
        else
        begin
            // Vectoring CORDIC: drive y to zero, accumulate the angle
            cx = b <<< PRESCALE_BITS;
            cy = a <<< PRESCALE_BITS;
            cz = 0;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (cy >= 0)
                begin
                    cx = cx + ys;
                    cy = cy - xs;
                    cz = cz + atan_tab[i];
                end
                else
                begin
                    cx = cx - ys;
                    cy = cy + xs;
                    cz = cz - atan_tab[i];
                end
            end
            phi = (cz + (longint'(1) <<< (ACC_FRAC_BITS - ANGLE_FRAC_BITS - 1)))
                  >>> (ACC_FRAC_BITS - ANGLE_FRAC_BITS);
            if (phi < 0)
                phi = 0;
            if (phi > RIGHT_ANGLE)
                phi = RIGHT_ANGLE;
        end
        h = minus ? base - phi : base + phi;
        h = h + longint'(decl_q);
        // Single wrap, direction chosen by the sign of the declination
        if (decl_q > 0)
        begin
            if (h > FULL_TURN)
                h = h - FULL_TURN;
        end
        else if (h < 0)
            h = h + FULL_TURN;
        r.heading = h[14:0];
        r.octant  = octant_of_heading(h);
        return r;
    endfunction

    // Axis sample: 0, 0xFFFF, random, or near half the offset (corrected axis near zero)
    function automatic logic [15:0] pick_axis(input logic [16:0] off_twice);
        longint c;
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3:
            begin
                c = longint'(off_twice / 2) + longint'($urandom_range(8)) - 4;
                if (c < 0) c = 0;
                if (c > 65535) c = 65535;
                return c[15:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] pick_offset();
        case ($urandom_range(3))
            0: return 17'd0;
            1: return 17'h1FFFF;
            2: return 17'd65536;
            default: return 17'($urandom_range(131071));
        endcase
    endfunction

    function automatic logic [16:0] pick_declination();
        logic signed [14:0] d;
        case ($urandom_range(4))
            0: d = -15'sd16384;
            1: d = 15'sd16383;
            2: d = 15'sd0;
            default: d = 15'(longint'($urandom_range(23040)) - 11520);
        endcase
        return {2'b00, d};
    endfunction

    function automatic void row_write(input logic [1:0] idx, input logic [16:0] val);
        stim_row_t r;
        r = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.wdata   = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_item(input logic [15:0] x, input logic [15:0] y,
                                     input logic typed = 1'b0,
                                     input logic [14:0] heading = 15'd0,
                                     input octant_t octant = OCT_N);
        stim_row_t r;
        r = '0;
        r.kind         = ROW_ITEM;
        r.x            = x;
        r.y            = y;
        r.typed        = typed;
        r.want.heading = heading;
        r.want.octant  = octant;
        directed_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Offer one item, with a random gap first, and return at the edge it is taken
    task automatic send_item(input logic [15:0] x, input logic [15:0] y);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every expected result, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_OFFSET_X:    off_x_q = val;
            REG_OFFSET_Y:    off_y_q = val;
            REG_DECLINATION: decl_q  = val[14:0];
            default: ;
        endcase
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_req && !hold_taken)
        begin
            m_tready   <= 1'b0;
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each result item with the oldest expectation
    always @(posedge clk)
    begin : result_check
        heading_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_headings.size() == 0)
                report_mismatch("unexpected result, m_tdata", m_tdata, 0);
            else
            begin
                want = pending_headings.pop_front();
                if (m_tdata[14:0] != want.heading)
                    report_mismatch("heading", m_tdata[14:0], want.heading);
                if (m_tdata[17:15] != want.octant)
                    report_mismatch("octant", m_tdata[17:15], want.octant);
                if (m_tdata[23:18] != 6'd0)
                    report_mismatch("padding", m_tdata[23:18], 0);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [15:0] x, y;

        // Directed table; typed expectations where the answer is plain
        // Reset registers: both axes zero, then each axis on its own
        row_item(16'd32768, 16'd32768, 1'b1, 15'd17498, OCT_W);
        row_item(16'd0,     16'd32768, 1'b1, 15'd5978,  OCT_E);
        row_item(16'd32768, 16'd65535, 1'b1, 15'd218,   OCT_N);
        row_item(16'd32768, 16'd0,     1'b1, 15'd11738, OCT_S);
        row_item(16'hFFFF, 16'hFFFF);
        row_item(16'h0000, 16'h0000);
        row_item(16'h0000, 16'hFFFF);
        row_item(16'hFFFF, 16'h0000);
        row_item(16'd32767, 16'd32769);
        row_item(16'hAAAA, 16'h5555);
        row_item(16'h5555, 16'hAAAA);
        // Unused index ignored; zero declination keeps a full 360
        row_write(REG_UNUSED, 17'h1FFFF);
        row_write(REG_DECLINATION, 17'd0);
        row_item(16'd32768, 16'd65535, 1'b1, 15'd23040, OCT_N);
        row_item(16'd32768, 16'd32768, 1'b1, 15'd17280, OCT_W);
        // Extreme offsets, most negative declination: wrap upwards
        row_write(REG_OFFSET_X, 17'd0);
        row_write(REG_OFFSET_Y, 17'h1FFFF);
        row_write(REG_DECLINATION, 17'h04000);
        row_item(16'h0000, 16'h0000, 1'b1, 15'd18176, OCT_W);
        row_item(16'hFFFF, 16'hFFFF);
        row_item(16'h0000, 16'hFFFF);
        // Opposite extremes, most positive declination
        row_write(REG_OFFSET_X, 17'h1FFFF);
        row_write(REG_OFFSET_Y, 17'd0);
        row_write(REG_DECLINATION, 17'h03FFF);
        row_item(16'hFFFF, 16'h0000, 1'b1, 15'd22143, OCT_N);
        row_item(16'h0000, 16'hFFFF);
        row_item(16'hFFFF, 16'hFFFF);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].wdata);
            end
            else
            begin
                send_item(directed_rows[k].x, directed_rows[k].y);
                pending_headings.push_back(directed_rows[k].typed ? directed_rows[k].want
                    : predict_heading(directed_rows[k].x, directed_rows[k].y));
            end
        end

        // Random part: three idle patterns, new registers for each chunk
        for (int mode = 0; mode < 3; mode++)
        begin
            wait_idle();
            case (mode)
                0:
                begin
                    tx_idle_pct <= 13;
                    rx_idle_pct <= 54;
                end
                1:
                begin
                    tx_idle_pct <= 54;
                    rx_idle_pct <= 13;
                end
                default:
                begin
                    tx_idle_pct   <= 0;
                    rx_idle_pct   <= 0;
                    long_hold_req <= 1'b1;
                end
            endcase
            @(posedge clk);
            for (int chunk = 0; chunk < 4; chunk++)
            begin
                if (chunk != 0)
                    wait_idle();
                write_reg(REG_OFFSET_X, pick_offset());
                write_reg(REG_OFFSET_Y, pick_offset());
                write_reg(REG_DECLINATION, pick_declination());
                if ($urandom_range(3) == 0)
                    write_reg(REG_UNUSED, 17'($urandom));
                repeat (CHUNK_ITEMS)
                begin
                    x = pick_axis(off_x_q);
                    y = pick_axis(off_y_q);
                    send_item(x, y);
                    pending_headings.push_back(predict_heading(x, y));
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
sv/chxy_pkg.sv
sv/chxy_cordic_cell.sv
sv/chxy_finish.sv
sv/compass_heading_from_xy.sv
tb/tb_compass_heading_from_xy.sv
